[hdl/gcd_pkg.sv]
// Package for the great-circle distance block: fixed-point types, constants,
// the CORDIC arctangent table and the shared Q30 helpers.
// No dependencies.
package gcd_pkg;

    // Working width of the CORDIC datapath (x, y and z).
    localparam int CW = 34;

    typedef logic signed [CW-1:0] cval_t;
    typedef logic [30:0]          q30_t;

    // One CORDIC lane: vector components and residual angle.
    typedef struct packed {
        cval_t x;
        cval_t y;
        cval_t z;
    } cordic_lane_t;

    // One square-root lane: remaining radicand and partial root.
    typedef struct packed {
        logic [63:0] n;
        logic [63:0] res;
    } sqrt_lane_t;

    typedef enum logic {
        CORDIC_ROTATE,
        CORDIC_VECTOR
    } cordic_mode_t;

    localparam logic [31:0]        DEG2RAD      = 32'd4024455254;
    localparam cval_t              CORDIC_GAIN  = 34'sd652032874;
    localparam q30_t               Q30_ONE      = 31'd1073741824;
    localparam logic [23:0]        TWO_R_M      = 24'd12742000;
    localparam logic [24:0]        MAX_DIST     = 25'd20015087;
    localparam logic signed [30:0] LAT_LIMIT    = 31'sd900000000;
    localparam logic signed [30:0] NEG_LAT_LIMIT = -31'sd900000000;
    localparam logic [31:0]        HALF_TURN    = 32'd1800000000;
    localparam logic [31:0]        FULL_TURN    = 32'd3600000000;

    // atan(2^-i) in Q30, truncated toward zero.
    function automatic cval_t atan_q30(input int i);
        cval_t r;
        case (i)
            0:  r = 34'sd843314856;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043836;
            3:  r = 34'sd133525158;
            4:  r = 34'sd67021686;
            5:  r = 34'sd33543515;
            6:  r = 34'sd16775850;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194282;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048575;
            11: r = 34'sd524287;
            12: r = 34'sd262143;
            13: r = 34'sd131071;
            14: r = 34'sd65535;
            15: r = 34'sd32767;
            16: r = 34'sd16383;
            17: r = 34'sd8191;
            18: r = 34'sd4095;
            19: r = 34'sd2047;
            20: r = 34'sd1023;
            21: r = 34'sd511;
            22: r = 34'sd255;
            23: r = 34'sd127;
            24: r = 34'sd63;
            25: r = 34'sd31;
            26: r = 34'sd15;
            27: r = 34'sd7;
            28: r = 34'sd3;
            29: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Clamp a CORDIC output to the range 0..1 in Q30.
    function automatic q30_t clamp_q30(input cval_t v);
        q30_t r;
        if (v < 0)
            r = '0;
        else if (v > cval_t'(Q30_ONE))
            r = Q30_ONE;
        else
            r = v[30:0];
        return r;
    endfunction

    // Product of two Q30 values, rounded to nearest with ties up.
    function automatic q30_t mul_q30(input q30_t a, input q30_t b);
        logic [62:0] p;
        p = 63'(a) * 63'(b) + 63'(64'd1 << 29);
        return p[60:30];
    endfunction

endpackage

[hdl/gcd_pt_if.sv]
// Request channel of the great-circle distance block: two points.
// Depends on nothing else.
interface gcd_pt_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;

    modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
    modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

[hdl/gcd_dist_if.sv]
// Result channel of the great-circle distance block: distance in metres.
// Depends on nothing else.
interface gcd_dist_if;
    logic        valid;
    logic        ready;
    logic [24:0] distance_m;

    modport source (output valid, distance_m, input ready);
    modport sink   (input valid, distance_m, output ready);
endinterface

[hdl/gcd_cordic_cell.sv]
// One CORDIC micro-rotation stage for a set of parallel lanes.
// Depends on gcd_pkg.
module gcd_cordic_cell #(
    parameter gcd_pkg::cordic_mode_t MODE = gcd_pkg::CORDIC_ROTATE,
    parameter int STEP  = 0,
    parameter int LANES = 1
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  valid_in,
    input  gcd_pkg::cordic_lane_t [LANES-1:0]     lane_in,
    output logic                                  valid_out,
    output gcd_pkg::cordic_lane_t [LANES-1:0]     lane_out
);
    import gcd_pkg::*;

    localparam cval_t ATAN = atan_q30(STEP);

    cordic_lane_t [LANES-1:0] lane_next;
    cordic_lane_t [LANES-1:0] lane_reg;
    logic                     valid_reg;

    // Rotation steers z toward zero; vectoring steers y toward zero.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic  dsel;
            cval_t dx;
            cval_t dy;
            dx = lane_in[l].y >>> STEP;
            dy = lane_in[l].x >>> STEP;
            if (MODE == CORDIC_ROTATE)
                dsel = (lane_in[l].z >= 0);
            else
                dsel = (lane_in[l].y < 0);
            lane_next[l].x = dsel ? lane_in[l].x - dx : lane_in[l].x + dx;
            lane_next[l].y = dsel ? lane_in[l].y + dy : lane_in[l].y - dy;
            lane_next[l].z = dsel ? lane_in[l].z - ATAN : lane_in[l].z + ATAN;
        end
    end

    // Payload stage.
    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    assign lane_out  = lane_reg;
    assign valid_out = valid_reg;

endmodule

[hdl/gcd_sqrt_cell.sv]
// One step of a restoring integer square root for parallel lanes.
// Depends on gcd_pkg.
module gcd_sqrt_cell #(
    parameter int STEP  = 0,
    parameter int LANES = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                valid_in,
    input  gcd_pkg::sqrt_lane_t [LANES-1:0]     lane_in,
    output logic                                valid_out,
    output gcd_pkg::sqrt_lane_t [LANES-1:0]     lane_out
);
    import gcd_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    sqrt_lane_t [LANES-1:0] lane_next;
    sqrt_lane_t [LANES-1:0] lane_reg;
    logic                   valid_reg;

    // Try to set this root bit; keep the remainder if it fits.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [63:0] trial;
            trial = lane_in[l].res + BIT;
            if (lane_in[l].n >= trial)
            begin
                lane_next[l].n   = lane_in[l].n - trial;
                lane_next[l].res = (lane_in[l].res >> 1) + BIT;
            end
            else
            begin
                lane_next[l].n   = lane_in[l].n;
                lane_next[l].res = lane_in[l].res >> 1;
            end
        end
    end

    // Payload stage.
    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    assign lane_out  = lane_reg;
    assign valid_out = valid_reg;

endmodule

[hdl/great_circle_distance.sv]
// Haversine great-circle distance, fully pipelined. A request holds two points
// (latitude and longitude in 1e-7 degree); the result is the distance in whole
// metres on a 6371 km sphere. One request is taken every clock cycle unless the
// pipeline holds, and each passes through three input stages, a chain
// of CORDIC_STEPS rotation cells, three multiply stages, 32 square-root cells,
// CORDIC_STEPS vectoring cells and two output stages. When the result is not
// taken the whole pipeline holds; it takes a new request in any cycle in which
// the output register is empty or being read.
// Depends on gcd_pkg, gcd_pt_if, gcd_dist_if, gcd_cordic_cell, gcd_sqrt_cell.
module great_circle_distance #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    gcd_pt_if.sink       points,
    gcd_dist_if.source   result
);
    import gcd_pkg::*;

    logic en;

    // Stage 1: clamped latitudes, longitude difference magnitude.
    logic               s1_vld_reg;
    logic signed [30:0] s1_la_reg, s1_lb_reg;
    logic [31:0]        s1_lon_reg;
    logic signed [30:0] la_next, lb_next;
    logic signed [32:0] lon_diff;
    logic [31:0]        lon_next;

    // Stage 2: angle magnitudes in 1e-7 degree.
    logic        s2_vld_reg;
    logic [30:0] s2_dlat_reg, s2_dlon_reg, s2_ma_reg, s2_mb_reg;
    logic signed [31:0] lat_diff;
    logic [31:0] lon_mod;
    logic [30:0] dlat_next, dlon_next, ma_next, mb_next;

    // Stage 3: radians in Q30.
    logic        s3_vld_reg;
    logic [30:0] s3_hlat_reg, s3_hlon_reg, s3_aa_reg, s3_ab_reg;
    logic [62:0] p_hlat, p_hlon, p_aa, p_ab;

    // Rotation chain.
    cordic_lane_t [3:0] rot_lane [CORDIC_STEPS+1];
    logic               rot_vld  [CORDIC_STEPS+1];

    // Stages 4 to 6: haversine terms and their sum.
    logic s4_vld_reg, s5_vld_reg, s6_vld_reg;
    q30_t s4_hlat_reg, s4_hlon_reg, s4_cc_reg;
    q30_t s5_hlat_reg, s5_t_reg;
    q30_t s6_v_reg;
    logic [31:0] v_sum;
    q30_t        v_next;

    // Square-root chain.
    sqrt_lane_t [1:0] sq_lane [33];
    logic             sq_vld  [33];

    // Vectoring chain.
    cordic_lane_t [0:0] vec_lane [CORDIC_STEPS+1];
    logic               vec_vld  [CORDIC_STEPS+1];

    // Stages 7 and 8: scale to metres.
    logic        s7_vld_reg, out_vld_reg;
    logic [54:0] s7_prod_reg;
    logic [30:0] ang_pos;
    logic [54:0] dist_sum;
    logic [24:0] out_dist_reg, dist_next;

    // The whole pipeline advances unless a result waits at the output.
    assign en           = !out_vld_reg || result.ready;
    assign points.ready = en;

    // Clamp latitudes and form the longitude difference magnitude.
    always_comb
    begin
        if (points.lat_a > LAT_LIMIT)
            la_next = LAT_LIMIT;
        else if (points.lat_a < NEG_LAT_LIMIT)
            la_next = NEG_LAT_LIMIT;
        else
            la_next = points.lat_a;
        if (points.lat_b > LAT_LIMIT)
            lb_next = LAT_LIMIT;
        else if (points.lat_b < NEG_LAT_LIMIT)
            lb_next = NEG_LAT_LIMIT;
        else
            lb_next = points.lat_b;
        lon_diff = {points.lon_b[31], points.lon_b} - {points.lon_a[31], points.lon_a};
        lon_next = lon_diff[32] ? 32'(-lon_diff) : lon_diff[31:0];
    end

    // Latitude difference and longitude reduced to 0..180 degrees.
    always_comb
    begin
        lat_diff  = {s1_lb_reg[30], s1_lb_reg} - {s1_la_reg[30], s1_la_reg};
        dlat_next = lat_diff[31] ? 31'(-lat_diff) : lat_diff[30:0];
        ma_next   = s1_la_reg[30] ? 31'(-s1_la_reg) : 31'(s1_la_reg);
        mb_next   = s1_lb_reg[30] ? 31'(-s1_lb_reg) : 31'(s1_lb_reg);
        lon_mod   = (s1_lon_reg >= FULL_TURN) ? s1_lon_reg - FULL_TURN : s1_lon_reg;
        dlon_next = (lon_mod > HALF_TURN) ? 31'(FULL_TURN - lon_mod) : lon_mod[30:0];
    end

    // Degrees to radians; half angles for the haversine terms.
    always_comb
    begin
        p_hlat = 63'(s2_dlat_reg) * 63'(DEG2RAD) + 63'(64'd1 << 31);
        p_hlon = 63'(s2_dlon_reg) * 63'(DEG2RAD) + 63'(64'd1 << 31);
        p_aa   = 63'(s2_ma_reg) * 63'(DEG2RAD) + 63'(64'd1 << 30);
        p_ab   = 63'(s2_mb_reg) * 63'(DEG2RAD) + 63'(64'd1 << 30);
    end

    // Payload registers of the front stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_la_reg   <= la_next;
            s1_lb_reg   <= lb_next;
            s1_lon_reg  <= lon_next;
            s2_dlat_reg <= dlat_next;
            s2_dlon_reg <= dlon_next;
            s2_ma_reg   <= ma_next;
            s2_mb_reg   <= mb_next;
            s3_hlat_reg <= p_hlat[62:32];
            s3_hlon_reg <= p_hlon[62:32];
            s3_aa_reg   <= p_aa[61:31];
            s3_ab_reg   <= p_ab[61:31];
        end
    end

    // Feed the rotation chain: lanes are half dlat, half dlon, lat a, lat b.
    always_comb
    begin
        rot_vld[0] = s3_vld_reg;
        for (int l = 0; l < 4; l++)
        begin
            rot_lane[0][l].x = CORDIC_GAIN;
            rot_lane[0][l].y = '0;
        end
        rot_lane[0][0].z = cval_t'(s3_hlat_reg);
        rot_lane[0][1].z = cval_t'(s3_hlon_reg);
        rot_lane[0][2].z = cval_t'(s3_aa_reg);
        rot_lane[0][3].z = cval_t'(s3_ab_reg);
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        gcd_cordic_cell #(
            .MODE  (CORDIC_ROTATE),
            .STEP  (i),
            .LANES (4)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (rot_vld[i]),
            .lane_in   (rot_lane[i]),
            .valid_out (rot_vld[i+1]),
            .lane_out  (rot_lane[i+1])
        );
    end

    // Sum of the haversine terms, saturated to one.
    always_comb
    begin
        v_sum  = 32'(s5_hlat_reg) + 32'(s5_t_reg);
        v_next = (v_sum > 32'(Q30_ONE)) ? Q30_ONE : v_sum[30:0];
    end

    // Payload registers of the multiply stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_hlat_reg <= mul_q30(clamp_q30(rot_lane[CORDIC_STEPS][0].y),
                                   clamp_q30(rot_lane[CORDIC_STEPS][0].y));
            s4_hlon_reg <= mul_q30(clamp_q30(rot_lane[CORDIC_STEPS][1].y),
                                   clamp_q30(rot_lane[CORDIC_STEPS][1].y));
            s4_cc_reg   <= mul_q30(clamp_q30(rot_lane[CORDIC_STEPS][2].x),
                                   clamp_q30(rot_lane[CORDIC_STEPS][3].x));
            s5_hlat_reg <= s4_hlat_reg;
            s5_t_reg    <= mul_q30(s4_cc_reg, s4_hlon_reg);
            s6_v_reg    <= v_next;
        end
    end

    // Feed the square-root chain with v and 1 - v, both scaled by 2^30.
    always_comb
    begin
        sq_vld[0]      = s6_vld_reg;
        sq_lane[0][0].n   = 64'(s6_v_reg) << 30;
        sq_lane[0][0].res = '0;
        sq_lane[0][1].n   = 64'(Q30_ONE - s6_v_reg) << 30;
        sq_lane[0][1].res = '0;
    end

    for (genvar k = 0; k < 32; k++)
    begin : g_sqrt
        gcd_sqrt_cell #(
            .STEP  (k),
            .LANES (2)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sq_vld[k]),
            .lane_in   (sq_lane[k]),
            .valid_out (sq_vld[k+1]),
            .lane_out  (sq_lane[k+1])
        );
    end

    // Feed the vectoring chain: atan2(sqrt v, sqrt(1 - v)).
    always_comb
    begin
        vec_vld[0]     = sq_vld[32];
        vec_lane[0][0].x = cval_t'(sq_lane[32][1].res[CW-1:0]);
        vec_lane[0][0].y = cval_t'(sq_lane[32][0].res[CW-1:0]);
        vec_lane[0][0].z = '0;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        gcd_cordic_cell #(
            .MODE  (CORDIC_VECTOR),
            .STEP  (i),
            .LANES (1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (vec_vld[i]),
            .lane_in   (vec_lane[i]),
            .valid_out (vec_vld[i+1]),
            .lane_out  (vec_lane[i+1])
        );
    end

    // Scale the central angle to metres, rounded and clamped.
    always_comb
    begin
        ang_pos   = (vec_lane[CORDIC_STEPS][0].z < 0) ? '0
                                                      : vec_lane[CORDIC_STEPS][0].z[30:0];
        dist_sum  = s7_prod_reg + 55'(64'd1 << 29);
        dist_next = (dist_sum[54:30] > MAX_DIST) ? MAX_DIST : dist_sum[54:30];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_prod_reg  <= 55'(ang_pos) * 55'(TWO_R_M);
            out_dist_reg <= dist_next;
        end
    end

    // Valid flags of the top-level stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= points.valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= rot_vld[CORDIC_STEPS];
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= vec_vld[CORDIC_STEPS];
            out_vld_reg <= s7_vld_reg;
        end
    end

    assign result.valid      = out_vld_reg;
    assign result.distance_m = out_dist_reg;

    // The saturated sum never exceeds one.
    a_v_range: assert property (@(posedge clk) disable iff (!rst_n)
        s6_vld_reg |-> s6_v_reg <= Q30_ONE)
        else $error("haversine sum above one");

    // Both roots stay within one in Q30.
    a_sqrt_range: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld[32] |-> (sq_lane[32][0].res <= 64'(Q30_ONE)
                        && sq_lane[32][1].res <= 64'(Q30_ONE)))
        else $error("square root out of range");

    // A stalled pipeline keeps its output result.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !result.ready) |=> (out_vld_reg && $stable(out_dist_reg)))
        else $error("result changed while stalled");

    // Distances never exceed half the circumference.
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> out_dist_reg <= MAX_DIST)
        else $error("distance above limit");

endmodule
